[sv/sil_pkg.sv]
// ----------------------------------------------------------------------------
// sil_pkg: shared types for the sorted insertion list
// Transfer payloads, cell control word, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int unsigned VAL_W     = 32;
    localparam int unsigned AVG_W     = 40;
    localparam int unsigned ENTRIES_W = 7;
    localparam int unsigned FRAC_W    = 8;

    typedef enum logic
    {
        KIND_INSERT = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed
    {
        logic signed [VAL_W-1:0]     element;
        logic                        last;
        logic                        empty_res;
        logic signed [VAL_W-1:0]     smallest;
        logic signed [VAL_W-1:0]     largest;
        logic signed [AVG_W-1:0]     average_q8;
        logic        [ENTRIES_W-1:0] entries;
        logic                        overflowed;
    } rsp_t;

    typedef enum logic [1:0]
    {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ROTATE = 2'd2
    } cell_op_t;

    typedef struct packed
    {
        cell_op_t                op;
        logic signed [VAL_W-1:0] x;
    } cell_ctrl_t;

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_SEND = 3'b100
    } state_t;

endpackage

`default_nettype wire

[sv/sil_cell.sv]
// ----------------------------------------------------------------------------
// sil_cell: one slot of the sorted chain
// Holds one value and its occupied bit; shifts right on insert, rotates
// left toward the head on report.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_cell
    import sil_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cell_ctrl_t              ctrl,
    input  wire logic                    prev_lt,
    input  wire logic                    prev_occ,
    input  wire logic signed [VAL_W-1:0] prev_val,
    input  wire logic                    next_occ,
    input  wire logic signed [VAL_W-1:0] next_val,
    input  wire logic signed [VAL_W-1:0] head_val,
    output logic                         occ,
    output logic                         lt,
    output logic signed [VAL_W-1:0]      val
);

    logic                    occ_reg;
    logic                    occ_next;
    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;

    assign lt  = occ_reg && (val_reg < ctrl.x);
    assign occ = occ_reg;
    assign val = val_reg;

    always_comb
    begin
        occ_next = occ_reg;
        val_next = val_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                occ_next = occ_reg | prev_occ;
                if (!lt)
                begin
                    val_next = prev_lt ? ctrl.x : prev_val;
                end
            end
            OP_ROTATE:
            begin
                if (occ_reg)
                begin
                    val_next = next_occ ? next_val : head_val;
                end
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

[sv/sil_div.sv]
// ----------------------------------------------------------------------------
// sil_div: serial divider for the mean
// Restoring division, one quotient bit per cycle; signed result by
// negating the magnitude quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_div
    import sil_pkg::*;
#(
    parameter int unsigned DVD_W = 46,
    parameter int unsigned CNT_W = 7
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    neg,
    input  wire logic [DVD_W-1:0]        dividend,
    input  wire logic [CNT_W-1:0]        divisor,
    output logic                         done,
    output logic signed [AVG_W-1:0]      quotient
);

    localparam int unsigned STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVD_W-1:0]  quo_next;
    logic              neg_reg;
    logic              neg_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    trial;
    logic [DVD_W-1:0]  signed_quo;

    assign shifted    = {rem_reg, quo_reg[DVD_W-1]};
    assign trial      = shifted - {1'b0, divisor};
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[AVG_W-1:0];
    assign done       = done_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

endmodule

`default_nettype wire

[sv/sorted_insert_list_stats_core.sv]
// ----------------------------------------------------------------------------
// sorted_insert_list_stats_core: sorted insertion list with statistics
// Insert: one transfer per cycle while idle, result-free; the chain of cells shifts
//   the tail right and drops the value into place as the transfer is accepted.
// Report: serial mean divider first (if non-empty), then one result per
//   cycle per stored value while not stalled (one result when empty); the
//   chain rotates once per result and is back in order after the last one.
// Reset: asynchronous, clears count, sum, overflow flag and occupied bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_list_stats_core
    import sil_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned SUM_W = VAL_W + $clog2(CAPACITY);
    localparam int unsigned DVD_W = SUM_W + FRAC_W;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        left_reg;
    logic [CNT_W-1:0]        left_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic signed [VAL_W-1:0] min_reg;
    logic signed [VAL_W-1:0] min_next;
    logic signed [VAL_W-1:0] max_reg;
    logic signed [VAL_W-1:0] max_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;

    cell_ctrl_t              ctrl;
    logic                    accept;
    logic                    full;
    logic                    out_free;
    logic                    div_start;
    logic                    div_done;
    logic signed [AVG_W-1:0] div_quo;
    logic [SUM_W-1:0]        sum_mag;
    logic [DVD_W-1:0]        dividend;
    logic [CNT_W+ENTRIES_W-1:0] count_wide;

    logic                    occ_w [CAPACITY];
    logic                    lt_w  [CAPACITY];
    logic signed [VAL_W-1:0] val_w [CAPACITY];

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dividend   = {sum_mag, {FRAC_W{1'b0}}};
    assign count_wide = {{ENTRIES_W{1'b0}}, count_reg};
    assign div_start  = accept && (req.kind == KIND_REPORT) && (count_reg != '0);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                    p_lt;
            logic                    p_occ;
            logic signed [VAL_W-1:0] p_val;
            logic                    n_occ;
            logic signed [VAL_W-1:0] n_val;

            if (gi == 0)
            begin : g_head
                assign p_lt  = 1'b1;
                assign p_occ = 1'b1;
                assign p_val = ctrl.x;
            end
            else
            begin : g_body
                assign p_lt  = lt_w[gi-1];
                assign p_occ = occ_w[gi-1];
                assign p_val = val_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign n_occ = 1'b0;
                assign n_val = val_w[0];
            end
            else
            begin : g_mid
                assign n_occ = occ_w[gi+1];
                assign n_val = val_w[gi+1];
            end

            sil_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .prev_lt  (p_lt),
                .prev_occ (p_occ),
                .prev_val (p_val),
                .next_occ (n_occ),
                .next_val (n_val),
                .head_val (val_w[0]),
                .occ      (occ_w[gi]),
                .lt       (lt_w[gi]),
                .val      (val_w[gi])
            );
        end
    endgenerate

    sil_div #(
        .DVD_W (DVD_W),
        .CNT_W (CNT_W)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .neg      (sum_reg[SUM_W-1]),
        .dividend (dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ctrl.op        = OP_HOLD;
        ctrl.x         = req.value;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_INSERT)
                    begin
                        if (full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.op    = OP_INSERT;
                            count_next = count_reg + 1'b1;
                            sum_next   = sum_reg + SUM_W'(req.value);
                            if (count_reg == '0 || req.value < min_reg)
                            begin
                                min_next = req.value;
                            end
                            if (count_reg == '0 || req.value > max_reg)
                            begin
                                max_next = req.value;
                            end
                        end
                    end
                    else
                    begin
                        left_next  = count_reg;
                        state_next = (count_reg == '0) ? S_SEND : S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.overflowed = ovf_reg;
                    if (left_reg == '0)
                    begin
                        rsp_next.element    = '0;
                        rsp_next.last       = 1'b1;
                        rsp_next.empty_res  = 1'b1;
                        rsp_next.smallest   = '0;
                        rsp_next.largest    = '0;
                        rsp_next.average_q8 = '0;
                        rsp_next.entries    = '0;
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        ctrl.op             = OP_ROTATE;
                        rsp_next.element    = val_w[0];
                        rsp_next.last       = (left_reg == CNT_W'(1));
                        rsp_next.empty_res  = 1'b0;
                        rsp_next.smallest   = min_reg;
                        rsp_next.largest    = max_reg;
                        rsp_next.average_q8 = div_quo;
                        rsp_next.entries    = count_wide[ENTRIES_W-1:0];
                        left_next           = left_reg - 1'b1;
                        if (left_reg == CNT_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

[sv/sil_checker.sv]
// ----------------------------------------------------------------------------
// sil_checker: port-level checks for the sorted insertion list
// Result framing and ordering of the reported statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_checker
    import sil_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.empty_res |-> rsp.last && rsp.entries == '0 && rsp.element == '0)
        else $error("empty result malformed");

    a_nonempty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.empty_res |-> rsp.smallest <= rsp.largest)
        else $error("smallest above largest");

    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.empty_res |->
            rsp.element >= rsp.smallest && rsp.element <= rsp.largest)
        else $error("element outside min/max");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp.last ##1 rsp_valid |->
            rsp.element >= $past(rsp.element))
        else $error("report not ascending");

endmodule

bind sorted_insert_list_stats_core sil_checker u_sil_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
